>>> src/hpf_pkg.sv
package hpf_pkg;

  localparam logic [7:0] CHAR_STX = 8'h02;
  localparam logic [7:0] CHAR_ETX = 8'h03;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // job opcodes passed from front to back
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;

  // job queue depth, power of two
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b0;       // command byte or data byte
    logic [7:0] b1;       // data length (start jobs)
    logic       trailer;  // append checksum and ETX after this job
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + n8;
    end else begin
      hex_digit = 8'h37 + n8;
    end
  endfunction

endpackage

>>> src/hpf_queue.sv
module hpf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  hpf_pkg::job_t wr_data,
  input  logic          rd_en,
  output hpf_pkg::job_t rd_data,
  output logic          full,
  output logic          nonempty
);
  import hpf_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> src/hpf_front.sv
module hpf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic          in_cmd,
  input  logic [7:0]    in_packet_command,
  input  logic [7:0]    in_data_len,
  input  logic [7:0]    in_data_byte,
  input  logic          q_full,
  output logic          q_wr,
  output hpf_pkg::job_t q_job
);
  import hpf_pkg::*;

  logic       open_r, open_nxt;
  logic [7:0] rem_r, rem_nxt;

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    open_nxt      = open_r;
    rem_nxt       = rem_r;
    q_job.op      = OP_ERROR;
    q_job.b0      = in_data_byte;
    q_job.b1      = in_data_len;
    q_job.trailer = 1'b0;
    if (in_cmd == KIND_START) begin
      q_job.op      = OP_START;
      q_job.b0      = in_packet_command;
      q_job.trailer = (in_data_len == 8'd0);
      rem_nxt       = in_data_len;
      open_nxt      = (in_data_len != 8'd0);
    end else if (open_r) begin
      q_job.op      = OP_DATA;
      q_job.trailer = (rem_r == 8'd1);
      rem_nxt       = rem_r - 8'd1;
      open_nxt      = (rem_r != 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= '0;
    end else if (q_wr) begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

>>> src/hpf_back.sv
module hpf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  hpf_pkg::job_t q_head,
  input  logic          q_nonempty,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_char,
  output logic          out_run_last,
  output logic          out_frame_end,
  output logic          out_item_error
);
  import hpf_pkg::*;

  localparam logic [3:0] PH_STX = 4'd0;
  localparam logic [3:0] PH_B0H = 4'd1;
  localparam logic [3:0] PH_B0L = 4'd2;
  localparam logic [3:0] PH_B1H = 4'd3;
  localparam logic [3:0] PH_B1L = 4'd4;
  localparam logic [3:0] PH_CKH = 4'd5;
  localparam logic [3:0] PH_CKL = 4'd6;
  localparam logic [3:0] PH_ETX = 4'd7;
  localparam logic [3:0] PH_ERR = 4'd8;

  logic       busy_r, busy_nxt;
  job_t       job_r, job_nxt;
  logic [3:0] ph_r, ph_nxt, ph_step, ph_first;
  logic [7:0] sum_r, sum_nxt;

  logic       oval_r;
  logic [7:0] ochar_r;
  logic       olast_r, oend_r, oerr_r;

  logic       adv, emit;
  logic [7:0] c;
  logic       summed, last, fe, err;

  assign adv  = !oval_r || pop;
  assign emit = busy_r && adv;

  always_comb begin
    c       = CHAR_NUL;
    summed  = 1'b0;
    last    = 1'b0;
    fe      = 1'b0;
    err     = 1'b0;
    ph_step = ph_r;
    case (ph_r)
      PH_STX: begin
        c = CHAR_STX; summed = 1'b1; ph_step = PH_B0H;
      end
      PH_B0H: begin
        c = hex_digit(job_r.b0[7:4]); summed = 1'b1; ph_step = PH_B0L;
      end
      PH_B0L: begin
        c = hex_digit(job_r.b0[3:0]); summed = 1'b1;
        if (job_r.op == OP_START) begin
          ph_step = PH_B1H;
        end else if (job_r.trailer) begin
          ph_step = PH_CKH;
        end else begin
          last = 1'b1;
        end
      end
      PH_B1H: begin
        c = hex_digit(job_r.b1[7:4]); summed = 1'b1; ph_step = PH_B1L;
      end
      PH_B1L: begin
        c = hex_digit(job_r.b1[3:0]); summed = 1'b1;
        if (job_r.trailer) begin
          ph_step = PH_CKH;
        end else begin
          last = 1'b1;
        end
      end
      PH_CKH: begin
        c = hex_digit(sum_r[7:4]); ph_step = PH_CKL;
      end
      PH_CKL: begin
        c = hex_digit(sum_r[3:0]); ph_step = PH_ETX;
      end
      PH_ETX: begin
        c = CHAR_ETX; fe = 1'b1; last = 1'b1;
      end
      PH_ERR: begin
        c = CHAR_NUL; err = 1'b1; last = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (q_head.op)
      OP_START: ph_first = PH_STX;
      OP_DATA:  ph_first = PH_B0H;
      default:  ph_first = PH_ERR;
    endcase
  end

  // next job loads back to back with the last character of the current one
  assign q_rd = q_nonempty && (!busy_r || (emit && last));

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    ph_nxt   = ph_r;
    sum_nxt  = sum_r;
    if (q_rd) begin
      busy_nxt = 1'b1;
      job_nxt  = q_head;
      ph_nxt   = ph_first;
    end else if (emit && last) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      ph_nxt = ph_step;
    end
    if (emit && summed) begin
      sum_nxt = (ph_r == PH_STX) ? CHAR_STX : sum_r + c;
    end else if (emit && fe) begin
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= PH_STX;
      sum_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      sum_r  <= sum_nxt;
      if (emit) begin
        oval_r <= 1'b1;
      end else if (pop) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      ochar_r <= c;
      olast_r <= last;
      oend_r  <= fe;
      oerr_r  <= err;
    end
  end

  assign empty          = !oval_r;
  assign out_char       = ochar_r;
  assign out_run_last   = olast_r;
  assign out_frame_end  = oend_r;
  assign out_item_error = oerr_r;

endmodule

>>> src/ascii_hex_packet_framer_top.sv
// Path: an item goes into the 4-entry job queue, which decouples the sides, then
// into the character sequencer, which registers each character at the output.
// Throughput: one character per cycle unless the output stalls; a data item yields
// 2 (5 with checksum and ETX), a stray one a NUL, a start item 5 (8 at zero length).
// Reset: synchronous, active low; closes any open packet, empties queue and output.
module ascii_hex_packet_framer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_cmd,
  input  logic [7:0] in_packet_command,
  input  logic [7:0] in_data_len,
  input  logic [7:0] in_data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_frame_end,
  output logic       out_item_error
);
  import hpf_pkg::*;

  job_t wr_job, head_job;
  logic q_wr, q_rd, q_full, q_nonempty;

  hpf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_cmd            (in_cmd),
    .in_packet_command (in_packet_command),
    .in_data_len       (in_data_len),
    .in_data_byte      (in_data_byte),
    .q_full            (q_full),
    .q_wr              (q_wr),
    .q_job             (wr_job)
  );

  hpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (wr_job),
    .rd_en    (q_rd),
    .rd_data  (head_job),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  hpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (head_job),
    .q_nonempty     (q_nonempty),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .out_char       (out_char),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end),
    .out_item_error (out_item_error)
  );

endmodule

>>> src/hpf_checker.sv
module hpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       out_run_last,
  input logic       out_frame_end,
  input logic       out_item_error
);
  import hpf_pkg::*;

  // ETX always closes the transaction run of its item
  a_etx_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> (out_run_last && out_char == CHAR_ETX))
    else $error("frame end without ETX or run_last");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item_error) |->
      (out_run_last && out_char == CHAR_NUL && !out_frame_end))
    else $error("error result malformed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("output not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char)))
    else $error("stalled result changed");

endmodule

bind ascii_hex_packet_framer_top hpf_checker u_hpf_checker (.*);

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hpf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fend;
    logic       err;
  } line_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_cmd = KIND_START;
  logic [7:0] in_packet_command = 8'h00;
  logic [7:0] in_data_len = 8'h00;
  logic [7:0] in_data_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_frame_end;
  logic       out_item_error;

  // framer state as the line should see it
  logic [7:0] chk_sum = 8'h00;
  logic [7:0] bytes_left = 8'h00;
  logic       frame_open = 1'b0;

  line_char_t pending_chars[$];

  int fail_count = 0;
  int items_sent = 0;
  int chars_checked = 0;
  int frames_closed = 0;
  int stray_errors = 0;
  int burst_left = 0;

  ascii_hex_packet_framer_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_cmd            (in_cmd),
    .in_packet_command (in_packet_command),
    .in_data_len       (in_data_len),
    .in_data_byte      (in_data_byte),
    .empty             (empty),
    .pop               (pop),
    .out_char          (out_char),
    .out_run_last      (out_run_last),
    .out_frame_end     (out_frame_end),
    .out_item_error    (out_item_error)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return 8'h41 + 8'(nib - 4'd10);
    end
    return 8'h30 + 8'(nib);
  endfunction

  task automatic emit(input logic [7:0] ch, input logic fend, input logic err);
    line_char_t c;
    c.ch   = ch;
    c.last = 1'b0;
    c.fend = fend;
    c.err  = err;
    pending_chars.push_back(c);
  endtask

  task automatic emit_summed(input logic [7:0] ch);
    chk_sum = chk_sum + ch;
    emit(ch, 1'b0, 1'b0);
  endtask

  task automatic emit_hex(input logic [7:0] b);
    emit_summed(ascii_nibble(b[7:4]));
    emit_summed(ascii_nibble(b[3:0]));
  endtask

  // checksum characters and ETX are not summed
  task automatic emit_trailer();
    emit(ascii_nibble(chk_sum[7:4]), 1'b0, 1'b0);
    emit(ascii_nibble(chk_sum[3:0]), 1'b0, 1'b0);
    emit(CHAR_ETX, 1'b1, 1'b0);
    frame_open = 1'b0;
    chk_sum    = 8'h00;
    bytes_left = 8'h00;
    frames_closed++;
  endtask

  task automatic frame_item(input logic kind, input logic [7:0] command,
                            input logic [7:0] length, input logic [7:0] payload);
    line_char_t tail;
    if (kind == KIND_START) begin
      // a start during an open packet just drops the old one
      chk_sum    = 8'h00;
      frame_open = 1'b1;
      bytes_left = length;
      emit_summed(CHAR_STX);
      emit_hex(command);
      emit_hex(length);
      if (bytes_left == 8'h00) begin
        emit_trailer();
      end
    end else if (!frame_open) begin
      emit(CHAR_NUL, 1'b0, 1'b1);
      stray_errors++;
    end else begin
      emit_hex(payload);
      bytes_left = bytes_left - 8'h01;
      if (bytes_left == 8'h00) begin
        emit_trailer();
      end
    end
    tail = pending_chars.pop_back();
    tail.last = 1'b1;
    pending_chars.push_back(tail);
  endtask

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      frame_item(in_cmd, in_packet_command, in_data_len, in_data_byte);
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    line_char_t want;
    if (rst_n && pop && !empty) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character 0x%02h on the line", out_char);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char);
          fail_count++;
        end
        if (out_run_last !== want.last) begin
          $error("out_run_last: expected %0b, got %0b", want.last, out_run_last);
          fail_count++;
        end
        if (out_frame_end !== want.fend) begin
          $error("out_frame_end: expected %0b, got %0b", want.fend, out_frame_end);
          fail_count++;
        end
        if (out_item_error !== want.err) begin
          $error("out_item_error: expected %0b, got %0b", want.err, out_item_error);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // stalls follow a rotating mask; when pop_phase wraps, pick a new mask or run flat out
  logic [15:0] pop_mask = 16'hFFFF;
  int          pop_phase = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop_phase == 63) begin
        pop_phase <= 0;
        if ($urandom_range(0, 3) == 0) begin
          pop_mask <= 16'hFFFF;
        end else begin
          pop_mask <= 16'($urandom()) | 16'h0001;
        end
      end else begin
        pop_phase <= pop_phase + 1;
        pop_mask  <= {pop_mask[14:0], pop_mask[15]};
      end
      pop <= pop_mask[0];
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_item(input logic kind, input logic [7:0] command,
                           input logic [7:0] length, input logic [7:0] payload);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    @(negedge clk);
    push = 1'b1;
    in_cmd = kind;
    // fields the item kind ignores still get random values
    in_packet_command = (kind == KIND_START) ? command : 8'($urandom());
    in_data_len       = (kind == KIND_START) ? length  : 8'($urandom());
    in_data_byte      = (kind == KIND_DATA)  ? payload : 8'($urandom());
    do @(posedge clk); while (full);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_line_drained();
    @(negedge clk);
    push = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_stray_data();
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'hFF);
  endtask

  task automatic test_empty_packets();
    send_item(KIND_START, 8'h00, 8'h00, 8'h00);
    send_item(KIND_START, 8'hFF, 8'h00, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h5A);
  endtask

  task automatic test_data_packets();
    send_item(KIND_START, 8'hA5, 8'h02, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'hFF);
    send_item(KIND_START, 8'h1F, 8'h01, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h5A);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'hC3);
  endtask

  task automatic test_abandon();
    send_item(KIND_START, 8'h3C, 8'hFF, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h9A);
    send_item(KIND_START, 8'h0E, 8'h01, 8'h00);
    send_item(KIND_START, 8'h80, 8'h7F, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h01);
    send_item(KIND_START, 8'h0E, 8'h01, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h1F);
    // hold off until the line is quiet, then restart from idle
    wait_line_drained();
    send_item(KIND_DATA, 8'h00, 8'h00, 8'h42);
  endtask

  task automatic test_random_packets(input int n_items);
    int   stop_at;
    int   n_data;
    logic [7:0] len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        // long or odd length, cut short by the next start
        len = 8'($urandom());
        n_data = $urandom_range(0, 3);
      end else begin
        len = 8'($urandom_range(0, 6));
        n_data = len;
      end
      if (n_data > len) begin
        n_data = len;
      end
      send_item(KIND_START, 8'($urandom()), len, 8'h00);
      repeat (n_data) send_item(KIND_DATA, 8'h00, 8'h00, 8'($urandom()));
      if (n_data == len && $urandom_range(0, 5) == 0) begin
        send_item(KIND_DATA, 8'h00, 8'h00, 8'($urandom()));
      end
      if ($urandom_range(0, 15) == 0) begin
        wait_line_drained();
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_stray_data();
    test_empty_packets();
    test_data_packets();
    test_abandon();
    test_random_packets(110);

    wait_line_drained();
    repeat (30) @(negedge clk);

    $display("Sent %0d items (packets of 0..255 length, abandoned packets, stray data)",
             items_sent);
    $display("Checked %0d characters: %0d frames closed, %0d stray data errors",
             chars_checked, frames_closed, stray_errors);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
